FILE: sv/okt_pkg.sv
`default_nettype none

package okt_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int PAYLOAD_DEF = 32;

  localparam int MODE_W = 4;
  localparam int POS_W  = 4;
  localparam int KEY_W  = 16;
  localparam int DATA_W = 32;
  localparam int FPOS_W = 4;
  localparam int CNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_APPEND       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INDEX_OF_KEY = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DATA_AT_IDX  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DATA_OF_KEY  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_REKEY        = 4'd5;
  localparam logic [MODE_W-1:0] MODE_KEY_AT_SET   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_KEY_AT_IDX   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_DATA_KEY_SET = 4'd8;
  localparam logic [MODE_W-1:0] MODE_DATA_AT_SET  = 4'd9;
  localparam logic [MODE_W-1:0] MODE_INDEX_OF_DAT = 4'd10;
  localparam logic [MODE_W-1:0] MODE_COUNT        = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_FIN
  } state_t;

  // Write address source.
  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_HIT,
    WA_PREV
  } wsel_t;

  typedef struct packed {
    logic  latch;
    logic  scan_clr;
    logic  scan_pos1;
    logic  rd_en;
    logic  rd_scan;
    logic  wr_key;
    logic  wr_pay;
    wsel_t wsel;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  res_ok;
    logic  res_fpos;
    logic  res_dout;
    logic  res_kout;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              pos_valid;
    logic              pend;
    logic              match;
    logic              more;
    logic              out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/okt_ctrl.sv
`default_nettype none

module okt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire okt_pkg::sts_t sts,
  output okt_pkg::cmd_t      cmd
);

  okt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= okt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wsel  = okt_pkg::WA_COUNT;
    in_ready  = 1'b0;
    unique case (state_r)
      okt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = okt_pkg::ST_DECODE;
        end
      end
      okt_pkg::ST_DECODE: begin
        state_nxt = okt_pkg::ST_FIN;
        unique case (sts.mode) inside
          okt_pkg::MODE_APPEND: begin
            if (!sts.full) begin
              cmd.wr_key  = 1'b1;
              cmd.wr_pay  = 1'b1;
              cmd.wsel    = okt_pkg::WA_COUNT;
              cmd.cnt_inc = 1'b1;
              cmd.res_ok  = 1'b1;
            end
          end
          okt_pkg::MODE_REMOVE: begin
            if (sts.pos_valid) begin
              cmd.scan_pos1 = 1'b1;
              state_nxt     = okt_pkg::ST_SHIFT;
            end
          end
          okt_pkg::MODE_INDEX_OF_KEY, okt_pkg::MODE_DATA_OF_KEY, okt_pkg::MODE_REKEY,
          okt_pkg::MODE_DATA_KEY_SET, okt_pkg::MODE_INDEX_OF_DAT: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = okt_pkg::ST_SCAN;
          end
          okt_pkg::MODE_DATA_AT_IDX, okt_pkg::MODE_KEY_AT_IDX: begin
            if (sts.pos_valid) begin
              cmd.rd_en = 1'b1;
              state_nxt = okt_pkg::ST_READ;
            end
          end
          okt_pkg::MODE_KEY_AT_SET: begin
            if (sts.pos_valid) begin
              cmd.wr_key = 1'b1;
              cmd.wsel   = okt_pkg::WA_POS;
              cmd.res_ok = 1'b1;
            end
          end
          okt_pkg::MODE_DATA_AT_SET: begin
            if (sts.pos_valid) begin
              cmd.wr_pay = 1'b1;
              cmd.wsel   = okt_pkg::WA_POS;
              cmd.res_ok = 1'b1;
            end
          end
          okt_pkg::MODE_COUNT: begin
            cmd.res_ok = 1'b1;
          end
          default: begin
          end
        endcase
      end
      okt_pkg::ST_SCAN: begin
        // Reads are issued one per cycle; the compare runs one entry behind.
        if (sts.pend && sts.match) begin
          cmd.res_ok = 1'b1;
          cmd.wsel   = okt_pkg::WA_HIT;
          cmd.res_fpos = (sts.mode == okt_pkg::MODE_INDEX_OF_KEY) ||
                         (sts.mode == okt_pkg::MODE_INDEX_OF_DAT);
          cmd.res_dout = (sts.mode == okt_pkg::MODE_DATA_OF_KEY);
          cmd.wr_key   = (sts.mode == okt_pkg::MODE_REKEY);
          cmd.wr_pay   = (sts.mode == okt_pkg::MODE_DATA_KEY_SET);
          state_nxt    = okt_pkg::ST_FIN;
        end else begin
          if (sts.more) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_scan = 1'b1;
          end
          if (!sts.pend && !sts.more) begin
            state_nxt = okt_pkg::ST_FIN;
          end
        end
      end
      okt_pkg::ST_SHIFT: begin
        // Each entry read at one address is written back one place lower.
        if (sts.pend) begin
          cmd.wr_key = 1'b1;
          cmd.wr_pay = 1'b1;
          cmd.wsel   = okt_pkg::WA_PREV;
        end
        if (sts.more) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_scan = 1'b1;
        end
        if (!sts.pend && !sts.more) begin
          cmd.cnt_dec = 1'b1;
          cmd.res_ok  = 1'b1;
          state_nxt   = okt_pkg::ST_FIN;
        end
      end
      okt_pkg::ST_READ: begin
        cmd.res_ok   = 1'b1;
        cmd.res_dout = (sts.mode == okt_pkg::MODE_DATA_AT_IDX);
        cmd.res_kout = (sts.mode == okt_pkg::MODE_KEY_AT_IDX);
        state_nxt    = okt_pkg::ST_FIN;
      end
      okt_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = okt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = okt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/okt_dpath.sv
`default_nettype none

module okt_dpath #(
  parameter int DEPTH        = okt_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = okt_pkg::PAYLOAD_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire okt_pkg::cmd_t                cmd,
  output okt_pkg::sts_t                     sts,
  input  wire logic [okt_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [okt_pkg::POS_W-1:0]    in_position,
  input  wire logic [okt_pkg::KEY_W-1:0]    in_key_id,
  input  wire logic [okt_pkg::KEY_W-1:0]    in_new_id,
  input  wire logic [okt_pkg::DATA_W-1:0]   in_data_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_ok,
  output logic [okt_pkg::FPOS_W-1:0]        out_found_position,
  output logic [okt_pkg::KEY_W-1:0]         out_key_out,
  output logic [okt_pkg::DATA_W-1:0]        out_data_out,
  output logic [okt_pkg::CNT_W-1:0]         out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = (CW > okt_pkg::POS_W) ? CW : okt_pkg::POS_W;
  localparam int PW = PAYLOAD_BITS;
  localparam int KW = okt_pkg::KEY_W;
  localparam int DW = okt_pkg::DATA_W;
  localparam int FW = okt_pkg::FPOS_W;
  localparam int NW = okt_pkg::CNT_W;

  logic [KW-1:0] key_mem [DEPTH];
  logic [PW-1:0] pay_mem [DEPTH];

  logic [okt_pkg::MODE_W-1:0] mode_r;
  logic [okt_pkg::POS_W-1:0]  pos_r;
  logic [KW-1:0]              key_r;
  logic [KW-1:0]              new_r;
  logic [PW-1:0]              data_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_r;
  logic          pend_r;
  logic [AW-1:0] addr_d_r;
  logic [KW-1:0] rd_key_r;
  logic [PW-1:0] rd_pay_r;

  logic          ok_r;
  logic [AW-1:0] fpos_r;
  logic [KW-1:0] kout_r;
  logic [PW-1:0] dout_r;

  logic          out_valid_r;
  logic          out_ok_r;
  logic [FW-1:0] out_fpos_r;
  logic [KW-1:0] out_key_r;
  logic [DW-1:0] out_data_r;
  logic [NW-1:0] out_cnt_r;

  logic [AW-1:0] pos_idx;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [KW-1:0] wkey;
  logic [PW-1:0] wpay;
  logic          shift_src;

  assign pos_idx   = AW'(pos_r);
  assign raddr     = cmd.rd_scan ? scan_r[AW-1:0] : pos_idx;
  assign shift_src = (cmd.wsel == okt_pkg::WA_PREV);

  always_comb begin
    unique case (cmd.wsel)
      okt_pkg::WA_COUNT: waddr = count_r[AW-1:0];
      okt_pkg::WA_POS:   waddr = pos_idx;
      okt_pkg::WA_HIT:   waddr = addr_d_r;
      okt_pkg::WA_PREV:  waddr = AW'(addr_d_r - 1'b1);
      default:           waddr = addr_d_r;
    endcase
  end

  always_comb begin
    if (shift_src) begin
      wkey = rd_key_r;
      wpay = rd_pay_r;
    end else begin
      wkey = (mode_r == okt_pkg::MODE_APPEND) ? key_r : new_r;
      wpay = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      key_mem[waddr] <= wkey;
    end
    if (cmd.wr_pay) begin
      pay_mem[waddr] <= wpay;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[raddr];
      rd_pay_r <= pay_mem[raddr];
      addr_d_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      key_r  <= in_key_id;
      new_r  <= in_new_id;
      data_r <= PW'(in_data_in);
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_pos1) begin
      scan_r <= CW'(pos_r) + 1'b1;
    end else if (cmd.rd_scan) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.latch) begin
      kout_r <= '0;
      dout_r <= '0;
      fpos_r <= '0;
    end else begin
      if (cmd.res_kout) begin
        kout_r <= rd_key_r;
      end
      if (cmd.res_dout) begin
        dout_r <= rd_pay_r;
      end
      if (cmd.res_fpos) begin
        fpos_r <= addr_d_r;
      end
    end
    if (cmd.out_load) begin
      out_ok_r   <= ok_r;
      out_fpos_r <= FW'(fpos_r);
      out_key_r  <= kout_r;
      out_data_r <= DW'(dout_r);
      out_cnt_r  <= NW'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_en;
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.latch) begin
        ok_r <= 1'b0;
      end else if (cmd.res_ok) begin
        ok_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.mode      = mode_r;
    sts.full      = (count_r == CW'(DEPTH));
    sts.pos_valid = (VW'(pos_r) < VW'(count_r));
    sts.pend      = pend_r;
    sts.match     = (mode_r == okt_pkg::MODE_INDEX_OF_DAT) ? (rd_pay_r == data_r)
                                                           : (rd_key_r == key_r);
    sts.more      = (scan_r < count_r);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_found_position = out_fpos_r;
  assign out_key_out        = out_key_r;
  assign out_data_out       = out_data_r;
  assign out_entry_count    = out_cnt_r;

endmodule

`default_nettype wire

FILE: sv/ordered_keyed_table_unit.sv
`default_nettype none

// Channel  Direction  Transfer when          Payload
// in_      input      in_valid & in_ready    mode, position, key_id, new_id, data_in
// out_     output     out_valid & out_ready  ok, found_position, key_out, data_out,
//                                            entry_count
//
// A request is taken in the idle state and decoded in the cycle after; once the work
// ends, its result is loaded into the output register. Key and payload searches and
// the gap closing of a remove walk the table memory one entry per cycle, and a search
// stops at a match. Reset clears the entry count and all handshake state; the table
// contents are not cleared. A waiting result does not block the next request, which
// stalls only when it is ready to deliver while the previous result is still untaken.

module ordered_keyed_table_unit #(
  parameter int DEPTH        = okt_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = okt_pkg::PAYLOAD_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [okt_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [okt_pkg::POS_W-1:0]    in_position,
  input  wire logic [okt_pkg::KEY_W-1:0]    in_key_id,
  input  wire logic [okt_pkg::KEY_W-1:0]    in_new_id,
  input  wire logic [okt_pkg::DATA_W-1:0]   in_data_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_ok,
  output logic [okt_pkg::FPOS_W-1:0]        out_found_position,
  output logic [okt_pkg::KEY_W-1:0]         out_key_out,
  output logic [okt_pkg::DATA_W-1:0]        out_data_out,
  output logic [okt_pkg::CNT_W-1:0]         out_entry_count
);

  okt_pkg::cmd_t cmd;
  okt_pkg::sts_t sts;

  okt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  okt_dpath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_key_id          (in_key_id),
    .in_new_id          (in_new_id),
    .in_data_in         (in_data_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_data_out       (out_data_out),
    .out_entry_count    (out_entry_count)
  );

endmodule

`default_nettype wire

FILE: tb/ordered_keyed_table_unit_test.sv
`timescale 1ns / 100ps

module ordered_keyed_table_unit_test;

  localparam int TABLE_DEPTH = okt_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASE_LEN = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int QUIET_FROM = 600;
  localparam int QUIET_TO = 760;
  localparam int HOLD_AT = 300;
  localparam int HOLD_LEN = 250;

  localparam logic [okt_pkg::MODE_W-1:0] MODE_FIRST_UNUSED = 4'd12;
  localparam logic [okt_pkg::MODE_W-1:0] MODE_LAST_UNUSED  = 4'd15;

  typedef logic [okt_pkg::MODE_W-1:0]     mode_bits_t;
  typedef logic [okt_pkg::POS_W-1:0]      pos_bits_t;
  typedef logic [okt_pkg::KEY_W-1:0]      key_bits_t;
  typedef logic [okt_pkg::FPOS_W-1:0]     fpos_bits_t;
  typedef logic [okt_pkg::CNT_W-1:0]      cnt_bits_t;
  typedef logic [$clog2(TABLE_DEPTH)-1:0] tbl_idx_t;
  typedef logic [2:0]                     pool_idx_t;

  typedef struct packed {
    logic [okt_pkg::MODE_W-1:0] mode;
    logic [okt_pkg::POS_W-1:0]  position;
    logic [okt_pkg::KEY_W-1:0]  key_id;
    logic [okt_pkg::KEY_W-1:0]  new_id;
    logic [okt_pkg::DATA_W-1:0] data_in;
  } table_request_t;

  typedef struct packed {
    logic                       ok;
    logic [okt_pkg::FPOS_W-1:0] found_position;
    logic [okt_pkg::KEY_W-1:0]  key_out;
    logic [okt_pkg::DATA_W-1:0] data_out;
    logic [okt_pkg::CNT_W-1:0]  entry_count;
  } table_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [okt_pkg::MODE_W-1:0] in_mode = '0;
  logic [okt_pkg::POS_W-1:0]  in_position = '0;
  logic [okt_pkg::KEY_W-1:0]  in_key_id = '0;
  logic [okt_pkg::KEY_W-1:0]  in_new_id = '0;
  logic [okt_pkg::DATA_W-1:0] in_data_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_ok;
  logic [okt_pkg::FPOS_W-1:0] out_found_position;
  logic [okt_pkg::KEY_W-1:0]  out_key_out;
  logic [okt_pkg::DATA_W-1:0] out_data_out;
  logic [okt_pkg::CNT_W-1:0]  out_entry_count;

  table_request_t pending_requests[$];
  table_result_t  expected_results[$];

  // Shadow copy of the table, updated as each request is accepted.
  logic [okt_pkg::KEY_W-1:0]  tbl_keys[TABLE_DEPTH];
  logic [okt_pkg::DATA_W-1:0] tbl_payloads[TABLE_DEPTH];
  int                         tbl_fill = 0;

  int mismatches = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int results_seen = 0;
  int hold_cycles = 0;
  bit hold_armed = 1'b1;

  logic [okt_pkg::KEY_W-1:0]  key_pool[8];
  logic [okt_pkg::DATA_W-1:0] data_pool[8];

  ordered_keyed_table_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_key_id          (in_key_id),
    .in_new_id          (in_new_id),
    .in_data_in         (in_data_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_data_out       (out_data_out),
    .out_entry_count    (out_entry_count)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic queue_request(input logic [okt_pkg::MODE_W-1:0] mode,
                               input logic [okt_pkg::POS_W-1:0] position,
                               input logic [okt_pkg::KEY_W-1:0] key_id,
                               input logic [okt_pkg::KEY_W-1:0] new_id,
                               input logic [okt_pkg::DATA_W-1:0] data_in);
    table_request_t r;
    r.mode = mode;
    r.position = position;
    r.key_id = key_id;
    r.new_id = new_id;
    r.data_in = data_in;
    pending_requests.push_back(r);
  endtask

  // Applies one request to the shadow table and returns the answer it must produce.
  function automatic table_result_t apply_table_request(input table_request_t r);
    table_result_t res;
    int key_hit;
    int data_hit;
    bit pos_ok;
    res = '0;
    key_hit = -1;
    data_hit = -1;
    pos_ok = r.position < tbl_fill;
    for (int i = tbl_fill - 1; i >= 0; i--) begin
      if (tbl_keys[tbl_idx_t'(i)] == r.key_id) key_hit = i;
      if (tbl_payloads[tbl_idx_t'(i)] == r.data_in) data_hit = i;
    end
    case (r.mode)
      okt_pkg::MODE_APPEND: begin
        if (tbl_fill < TABLE_DEPTH) begin
          tbl_keys[tbl_idx_t'(tbl_fill)] = r.key_id;
          tbl_payloads[tbl_idx_t'(tbl_fill)] = r.data_in;
          tbl_fill++;
          res.ok = 1'b1;
        end
      end
      okt_pkg::MODE_REMOVE: begin
        if (pos_ok) begin
          for (int i = r.position; i < tbl_fill - 1; i++) begin
            tbl_keys[tbl_idx_t'(i)] = tbl_keys[tbl_idx_t'(i + 1)];
            tbl_payloads[tbl_idx_t'(i)] = tbl_payloads[tbl_idx_t'(i + 1)];
          end
          tbl_fill--;
          res.ok = 1'b1;
        end
      end
      okt_pkg::MODE_INDEX_OF_KEY: begin
        if (key_hit >= 0) begin
          res.ok = 1'b1;
          res.found_position = fpos_bits_t'(key_hit);
        end
      end
      okt_pkg::MODE_DATA_AT_IDX: begin
        if (pos_ok) begin
          res.ok = 1'b1;
          res.data_out = tbl_payloads[tbl_idx_t'(r.position)];
        end
      end
      okt_pkg::MODE_DATA_OF_KEY: begin
        if (key_hit >= 0) begin
          res.ok = 1'b1;
          res.data_out = tbl_payloads[tbl_idx_t'(key_hit)];
        end
      end
      okt_pkg::MODE_REKEY: begin
        if (key_hit >= 0) begin
          res.ok = 1'b1;
          tbl_keys[tbl_idx_t'(key_hit)] = r.new_id;
        end
      end
      okt_pkg::MODE_KEY_AT_SET: begin
        if (pos_ok) begin
          res.ok = 1'b1;
          tbl_keys[tbl_idx_t'(r.position)] = r.new_id;
        end
      end
      okt_pkg::MODE_KEY_AT_IDX: begin
        if (pos_ok) begin
          res.ok = 1'b1;
          res.key_out = tbl_keys[tbl_idx_t'(r.position)];
        end
      end
      okt_pkg::MODE_DATA_KEY_SET: begin
        if (key_hit >= 0) begin
          res.ok = 1'b1;
          tbl_payloads[tbl_idx_t'(key_hit)] = r.data_in;
        end
      end
      okt_pkg::MODE_DATA_AT_SET: begin
        if (pos_ok) begin
          res.ok = 1'b1;
          tbl_payloads[tbl_idx_t'(r.position)] = r.data_in;
        end
      end
      okt_pkg::MODE_INDEX_OF_DAT: begin
        if (data_hit >= 0) begin
          res.ok = 1'b1;
          res.found_position = fpos_bits_t'(data_hit);
        end
      end
      okt_pkg::MODE_COUNT: res.ok = 1'b1;
      default: ;
    endcase
    res.entry_count = cnt_bits_t'(tbl_fill);
    return res;
  endfunction

  always @(posedge clk) begin : drive_requests
    table_request_t r;
    bit pause;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = '{in_mode, in_position, in_key_id, in_new_id, in_data_in};
        expected_results.push_back(apply_table_request(r));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        pause = ($urandom_range(0, 99) < 9) &&
                !(sent_count >= QUIET_FROM && sent_count < QUIET_TO);
        if (pending_requests.size() != 0 && !pause) begin
          r = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_mode <= r.mode;
          in_position <= r.position;
          in_key_id <= r.key_id;
          in_new_id <= r.new_id;
          in_data_in <= r.data_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    table_result_t want;
    bit stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_ok !== want.ok)
            report_mismatch($sformatf("ok: got %0b, expected %0b", out_ok, want.ok));
          if (out_found_position !== want.found_position)
            report_mismatch($sformatf("found_position: got %0d, expected %0d",
                                      out_found_position, want.found_position));
          if (out_key_out !== want.key_out)
            report_mismatch($sformatf("key_out: got %h, expected %h",
                                      out_key_out, want.key_out));
          if (out_data_out !== want.data_out)
            report_mismatch($sformatf("data_out: got %h, expected %h",
                                      out_data_out, want.data_out));
          if (out_entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count: got %0d, expected %0d",
                                      out_entry_count, want.entry_count));
        end
      end
      stall = ($urandom_range(0, 99) < 9) &&
              !(results_seen >= QUIET_FROM && results_seen < QUIET_TO);
      out_ready <= !(stall || hold_cycles != 0);
    end
  end

  // One long hold-off on the result side lets the block back up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && results_seen == HOLD_AT) begin
      hold_cycles <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [okt_pkg::MODE_W-1:0] mode;
    logic [okt_pkg::POS_W-1:0]  position;
    int roll;
    int phase;

    key_pool[0] = '0;
    key_pool[1] = '1;
    data_pool[0] = '0;
    data_pool[1] = '1;
    for (int i = 2; i < 8; i++) begin
      key_pool[pool_idx_t'(i)] = key_bits_t'($urandom);
      data_pool[pool_idx_t'(i)] = $urandom;
    end

    // Searches and index requests against an empty table.
    queue_request(okt_pkg::MODE_COUNT, 4'd0, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_INDEX_OF_KEY, 4'd0, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_INDEX_OF_DAT, 4'd0, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_REMOVE, 4'd0, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_DATA_OF_KEY, 4'd0, 16'h0000, 16'h0000, 32'h0);
    // Extreme keys and payloads, with a duplicate key so the first match counts.
    queue_request(okt_pkg::MODE_APPEND, 4'd0, 16'h0000, 16'hFFFF, 32'h0000_0000);
    queue_request(okt_pkg::MODE_APPEND, 4'd15, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    queue_request(okt_pkg::MODE_APPEND, 4'd0, 16'hFFFF, 16'h0000, 32'h5A5A_A5A5);
    queue_request(okt_pkg::MODE_INDEX_OF_KEY, 4'd0, 16'hFFFF, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_INDEX_OF_DAT, 4'd0, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    queue_request(okt_pkg::MODE_REKEY, 4'd0, 16'hFFFF, 16'h1234, 32'h0);
    queue_request(okt_pkg::MODE_KEY_AT_IDX, 4'd1, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_KEY_AT_SET, 4'd2, 16'h0000, 16'hABCD, 32'h0);
    queue_request(okt_pkg::MODE_DATA_KEY_SET, 4'd0, 16'h1234, 16'h0000, 32'hC3C3_0F0F);
    queue_request(okt_pkg::MODE_DATA_OF_KEY, 4'd0, 16'h1234, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_DATA_AT_SET, 4'd0, 16'h0000, 16'h0000, 32'h8000_0001);
    queue_request(okt_pkg::MODE_DATA_AT_IDX, 4'd0, 16'h0000, 16'h0000, 32'h0);
    // Positions at or beyond the count must fail.
    queue_request(okt_pkg::MODE_KEY_AT_IDX, 4'd15, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_DATA_AT_IDX, 4'd3, 16'h0000, 16'h0000, 32'h0);
    queue_request(MODE_FIRST_UNUSED, 4'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_request(MODE_LAST_UNUSED, 4'd0, 16'h0000, 16'h0000, 32'h0);
    // Removing the oldest entry shifts the rest down; then remove the last one.
    queue_request(okt_pkg::MODE_REMOVE, 4'd0, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_KEY_AT_IDX, 4'd0, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_REMOVE, 4'd1, 16'h0000, 16'h0000, 32'h0);
    queue_request(okt_pkg::MODE_COUNT, 4'd0, 16'h0000, 16'h0000, 32'h0);

    // Random part in phases that fill the table, drain it, or mix all requests.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / PHASE_LEN) % 3;
      roll = $urandom_range(0, 99);
      if (phase == 2) begin
        mode = mode_bits_t'($urandom_range(okt_pkg::MODE_APPEND, MODE_LAST_UNUSED));
      end else if (phase == 0) begin
        if (roll < 55) mode = okt_pkg::MODE_APPEND;
        else if (roll < 60) mode = okt_pkg::MODE_REMOVE;
        else if (roll < 62)
          mode = mode_bits_t'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
        else
          mode = mode_bits_t'($urandom_range(okt_pkg::MODE_INDEX_OF_KEY, okt_pkg::MODE_COUNT));
      end else begin
        if (roll < 40) mode = okt_pkg::MODE_REMOVE;
        else if (roll < 50) mode = okt_pkg::MODE_APPEND;
        else if (roll < 52)
          mode = mode_bits_t'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
        else
          mode = mode_bits_t'($urandom_range(okt_pkg::MODE_INDEX_OF_KEY, okt_pkg::MODE_COUNT));
      end
      if ($urandom_range(0, 99) < 40) position = pos_bits_t'($urandom_range(0, 4));
      else position = pos_bits_t'($urandom_range(0, TABLE_DEPTH - 1));
      queue_request(mode, position,
                    ($urandom_range(0, 99) < 85) ? key_pool[pool_idx_t'($urandom_range(0, 7))]
                                                 : key_bits_t'($urandom),
                    ($urandom_range(0, 99) < 50) ? key_pool[pool_idx_t'($urandom_range(0, 7))]
                                                 : key_bits_t'($urandom),
                    ($urandom_range(0, 99) < 75) ? data_pool[pool_idx_t'($urandom_range(0, 7))]
                                                 : $urandom);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: ordered_keyed_table_unit.f
sv/okt_pkg.sv
sv/okt_ctrl.sv
sv/okt_dpath.sv
sv/ordered_keyed_table_unit.sv
tb/ordered_keyed_table_unit_test.sv
